@@ src/lzs_pkg.sv @@
// Shared types and constants for the layer z-order stack.
// No dependencies; used by lzs_cell, lzs_group and layer_zorder_stack_core.
`default_nettype none

package lzs_pkg;

   localparam int unsigned SLOT_W   = 8;   // slot field of a transaction
   localparam int unsigned HT_W     = 9;   // signed stacking height, -1 hidden
   localparam int unsigned RNG_W    = HT_W + 1; // shift bounds, room for top+1
   localparam int unsigned IDX_W    = 10;  // cell index, covers up to 1024 slots
   localparam int unsigned GRP_SIZE = 16;  // cells per reduction group

   localparam logic [HT_W-1:0] HT_HIDDEN = '1;

   typedef enum logic [1:0] {
      REQ_ALLOC = 2'd0,
      REQ_SET   = 2'd1,
      REQ_FREE  = 2'd2,
      REQ_NOP   = 2'd3
   } req_kind_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             apply;
      logic [IDX_W-1:0] slot;
      logic             shift_en;
      logic             shift_up;
      logic [RNG_W-1:0] lo;
      logic [RNG_W-1:0] hi;
      logic             tgt_en;
      logic [HT_W-1:0]  tgt_height;
      logic             use_set;
      logic             use_clr;
   } cell_cmd_type;

   // what one cell reports to its group
   typedef struct packed {
      logic            free;
      logic            hit_use;
      logic [HT_W-1:0] hit_height;
   } cell_stat_type;

   // registered summary of one group of cells
   typedef struct packed {
      logic             any_free;
      logic [IDX_W-1:0] free_idx;
      logic             hit_use;
      logic [HT_W-1:0]  hit_height;
   } grp_stat_type;

endpackage

`default_nettype wire

@@ src/lzs_cell.sv @@
// One slot cell: in-use flag and stacking height of a single layer slot.
// Depends on lzs_pkg for the command and status structs.
`default_nettype none

module lzs_cell #(
   parameter int unsigned IDX = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  lzs_pkg::cell_cmd_type cmd,
   output lzs_pkg::cell_stat_type stat
);

   logic                       use_ff, use_in;
   logic [lzs_pkg::HT_W-1:0]   ht_ff, ht_in;
   logic [lzs_pkg::RNG_W-1:0]  ht_wide;
   logic                       hit;
   logic                       in_range;

   assign hit      = (cmd.slot == lzs_pkg::IDX_W'(IDX));
   assign ht_wide  = {ht_ff[lzs_pkg::HT_W-1], ht_ff};
   assign in_range = ($signed(ht_wide) >= $signed(cmd.lo))
                  && ($signed(ht_wide) <= $signed(cmd.hi));

   always_comb begin
      use_in = use_ff;
      ht_in  = ht_ff;
      if (cmd.apply) begin
         // renumber entries between the old and new height
         if (cmd.shift_en && in_range) begin
            ht_in = cmd.shift_up ? ht_ff + lzs_pkg::HT_W'(1) : ht_ff - lzs_pkg::HT_W'(1);
         end
         if (hit && cmd.tgt_en) begin
            ht_in = cmd.tgt_height;
         end
         if (hit && cmd.use_set) begin
            use_in = 1'b1;
         end
         if (hit && cmd.use_clr) begin
            use_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= 1'b0;
         ht_ff  <= lzs_pkg::HT_HIDDEN;
      end else begin
         use_ff <= use_in;
         ht_ff  <= ht_in;
      end
   end

   assign stat.free       = ~use_ff;
   assign stat.hit_use    = hit & use_ff;
   assign stat.hit_height = hit ? ht_ff : '0;

endmodule

`default_nettype wire

@@ src/lzs_group.sv @@
// Registered reduction over one group of slot cells: lowest free slot and
// the state of the addressed slot. Depends on lzs_pkg.
`default_nettype none

module lzs_group #(
   parameter int unsigned BASE = 0
) (
   input  wire                                                clock,
   input  lzs_pkg::cell_stat_type [lzs_pkg::GRP_SIZE-1:0]     stat,
   output lzs_pkg::grp_stat_type                              grp
);

   lzs_pkg::grp_stat_type grp_ff, grp_in;

   always_comb begin
      grp_in = '0;
      // lowest index wins: scan downwards
      for (int k = lzs_pkg::GRP_SIZE - 1; k >= 0; k--) begin
         if (stat[k].free) begin
            grp_in.any_free = 1'b1;
            grp_in.free_idx = lzs_pkg::IDX_W'(BASE + k);
         end
      end
      for (int k = 0; k < lzs_pkg::GRP_SIZE; k++) begin
         grp_in.hit_use    = grp_in.hit_use | stat[k].hit_use;
         grp_in.hit_height = grp_in.hit_height | stat[k].hit_height;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp = grp_ff;

endmodule

`default_nettype wire

@@ src/layer_zorder_stack_core.sv @@
// Layer z-order stack: top level. Holds the slot cells, the group reduction
// stages and the request sequencer. Depends on lzs_pkg, lzs_cell, lzs_group.
`default_nettype none

// Keeps a pool of MAX_LAYERS display layer slots and their stacking order.
// Each slot lives in a cell of its own that holds its in-use flag and its
// height; a move is broadcast to all cells at once, so every entry between
// the old and the new height is renumbered together. One transaction is
// handled at a time: after acceptance comes a lookup state in which
// 16-cell groups register the addressed slot and their lowest free slot, a
// select state that reduces the groups, and an execute state that clamps
// the height, updates the cells and loads the result register. A new
// transaction is taken the cycle after execution, also while the previous
// result still waits; execution holds only while the result register is
// full. The group reduction sets the lookup latency. There is no clearing
// pass: reset clears every cell at once.
module layer_zorder_stack_core #(
   parameter int unsigned MAX_LAYERS = 256
) (
   input  wire                           clock,
   input  wire                           reset,
   // request transactions
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [1:0]                    req_type,
   input  wire  [lzs_pkg::SLOT_W-1:0]    req_slot,
   input  wire  signed [lzs_pkg::HT_W-1:0] req_new_height,
   // result transactions
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_status,
   output logic [lzs_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic signed [lzs_pkg::HT_W-1:0] rsp_layer_height,
   output logic signed [lzs_pkg::HT_W-1:0] rsp_top_height,
   output logic                          rsp_redraw
);

   localparam int unsigned NG = (MAX_LAYERS + lzs_pkg::GRP_SIZE - 1) / lzs_pkg::GRP_SIZE;
   localparam int unsigned NC = NG * lzs_pkg::GRP_SIZE;
   localparam int unsigned HW = lzs_pkg::HT_W;
   localparam int unsigned RW = lzs_pkg::RNG_W;
   localparam int unsigned IW = lzs_pkg::IDX_W;
   localparam logic signed [RW-1:0] NEG_ONE = '1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_SEL  = 4'b0100,
      S_EXEC = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // request held for the whole transaction
   lzs_pkg::req_kind_type      req_type_ff;
   logic [lzs_pkg::SLOT_W-1:0] req_slot_ff;
   logic [HW-1:0]              req_ht_ff;

   // results of the select stage
   logic [HW-1:0] old_ht_ff, old_ht_in;
   logic          hit_use_ff, hit_use_in;
   logic          found_ff, found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic [HW-1:0] top_ff, top_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic [lzs_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [HW-1:0]              rsp_lh_ff, rsp_lh_in;
   logic [HW-1:0]              rsp_top_ff;
   logic                       rsp_redraw_ff, rsp_redraw_in;

   lzs_pkg::cell_cmd_type                       cmd;
   lzs_pkg::cell_stat_type [NC-1:0]             stat;
   lzs_pkg::grp_stat_type  [NG-1:0]             grp;

   logic exec_go;
   logic slot_ok;
   logic is_alloc, op_set, op_free, move, changed, up;
   logic signed [RW-1:0] old_w, top_w, lim_w, want_w, nh_w;

   // ---------------------------------------------------------------- cells
   for (genvar i = 0; i < NC; i++) begin : g_cell
      if (i < MAX_LAYERS) begin : g_live
         lzs_cell #(.IDX(i)) u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .stat  (stat[i])
         );
      end else begin : g_pad
         // padding past the last slot: never free, never addressed
         assign stat[i] = '0;
      end
   end

   for (genvar g = 0; g < NG; g++) begin : g_grp
      lzs_group #(.BASE(g * lzs_pkg::GRP_SIZE)) u_grp (
         .clock (clock),
         .stat  (stat[g*lzs_pkg::GRP_SIZE +: lzs_pkg::GRP_SIZE]),
         .grp   (grp[g])
      );
   end

   // ------------------------------------------------------------ sequencer
   assign req_ready = (state_ff == S_IDLE);
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = (req_valid && req_ready) ? S_LOOK : S_IDLE;
         S_LOOK:  state_in = S_SEL;
         S_SEL:   state_in = S_EXEC;
         S_EXEC:  state_in = exec_go ? S_IDLE : S_EXEC;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the request for the duration of the transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_type_ff <= lzs_pkg::req_kind_type'(req_type);
         req_slot_ff <= req_slot;
         req_ht_ff   <= req_new_height;
      end
   end

   // ---------------------------------------------------------- select stage
   // Reduce the group summaries: lowest free slot overall, and the addressed
   // slot's flag and height (only its own group reports a non-zero value).
   always_comb begin
      found_in    = 1'b0;
      free_idx_in = '0;
      hit_use_in  = 1'b0;
      old_ht_in   = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp[g].any_free) begin
            found_in    = 1'b1;
            free_idx_in = grp[g].free_idx;
         end
      end
      for (int g = 0; g < NG; g++) begin
         hit_use_in = hit_use_in | grp[g].hit_use;
         old_ht_in  = old_ht_in | grp[g].hit_height;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SEL) begin
         found_ff    <= found_in;
         free_idx_ff <= free_idx_in;
         hit_use_ff  <= hit_use_in;
         old_ht_ff   <= old_ht_in;
      end
   end

   // --------------------------------------------------------- execute stage
   assign slot_ok  = 32'(req_slot_ff) < 32'(MAX_LAYERS);
   assign is_alloc = (req_type_ff == lzs_pkg::REQ_ALLOC);
   assign op_set   = (req_type_ff == lzs_pkg::REQ_SET) && slot_ok && hit_use_ff;
   // free moves the slot out of the stack only when it is visible
   assign op_free  = (req_type_ff == lzs_pkg::REQ_FREE) && slot_ok && !old_ht_ff[HW-1];
   assign move     = op_set || op_free;

   assign old_w  = {old_ht_ff[HW-1], old_ht_ff};
   assign top_w  = {top_ff[HW-1], top_ff};
   assign want_w = op_set ? {req_ht_ff[HW-1], req_ht_ff} : NEG_ONE;
   // a hidden slot may go one above the top, a visible one only to the top
   assign lim_w  = old_w[RW-1] ? top_w + RW'(1) : top_w;

   always_comb begin
      nh_w = (want_w > lim_w) ? lim_w : want_w;
      if (nh_w < NEG_ONE) begin
         nh_w = NEG_ONE;
      end
   end

   assign changed = move && (nh_w != old_w);
   // upward renumbering when the slot drops below entries it passes
   assign up      = !nh_w[RW-1] && (old_w[RW-1] || (nh_w < old_w));

   always_comb begin
      cmd            = '0;
      cmd.apply      = exec_go;
      cmd.slot       = is_alloc ? free_idx_ff : IW'(req_slot_ff);
      cmd.shift_en   = changed;
      cmd.shift_up   = up;
      cmd.lo         = up ? nh_w : old_w + RW'(1);
      if (up) begin
         cmd.hi = old_w[RW-1] ? top_w : old_w - RW'(1);
      end else begin
         cmd.hi = nh_w[RW-1] ? top_w : nh_w;
      end
      cmd.tgt_en     = changed;
      cmd.tgt_height = nh_w[HW-1:0];
      cmd.use_set    = is_alloc && found_ff;
      cmd.use_clr    = (req_type_ff == lzs_pkg::REQ_FREE) && slot_ok;
   end

   always_comb begin
      top_in = top_ff;
      if (exec_go && changed) begin
         if (old_w[RW-1]) begin
            top_in = top_ff + HW'(1);
         end else if (nh_w[RW-1]) begin
            top_in = top_ff - HW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= lzs_pkg::HT_HIDDEN;
      end else begin
         top_ff <= top_in;
      end
   end

   // ------------------------------------------------------- result register
   always_comb begin
      rsp_status_in = 1'b0;
      rsp_slot_in   = req_slot_ff;
      rsp_lh_in     = lzs_pkg::HT_HIDDEN;
      rsp_redraw_in = changed;
      case (req_type_ff)
         lzs_pkg::REQ_ALLOC: begin
            rsp_status_in = !found_ff;
            rsp_slot_in   = found_ff ? free_idx_ff[lzs_pkg::SLOT_W-1:0] : '0;
         end
         lzs_pkg::REQ_SET: begin
            if (slot_ok) begin
               rsp_lh_in = changed ? nh_w[HW-1:0] : old_ht_ff;
            end
         end
         lzs_pkg::REQ_FREE: begin
            rsp_lh_in = lzs_pkg::HT_HIDDEN;
         end
         default: begin
            if (slot_ok) begin
               rsp_lh_in = old_ht_ff;
            end
         end
      endcase
   end

   always_comb begin
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the payload only when a transaction completes
   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_lh_ff     <= rsp_lh_in;
         rsp_top_ff    <= top_in;
         rsp_redraw_ff <= rsp_redraw_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_layer_height = rsp_lh_ff;
   assign rsp_top_height   = rsp_top_ff;
   assign rsp_redraw       = rsp_redraw_ff;

`ifndef SYNTHESIS
   // top moves only when a command is applied to the cells
   a_top_only_on_apply: assert property (@(posedge clock) disable iff (reset)
      !cmd.apply |=> (top_ff == $past(top_ff)))
      else $error("top height changed without an applied command");

   // an accepted transaction goes straight to the lookup cycle
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LOOK))
      else $error("accepted transaction did not start lookup");

   // an executed transaction always leaves a result behind
   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff)
      else $error("executed transaction produced no result");

   // a failed allocate changes nothing
   a_fail_no_redraw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (!rsp_redraw_ff && (rsp_slot_ff == '0)))
      else $error("failed allocate reported a change or a slot");
`endif

endmodule

`default_nettype wire

@@ test/tb_layer_zorder_stack_core.sv @@
// Self-checking bench for layer_zorder_stack_core: directed table then weighted random traffic.
// Depends on lzs_pkg (request kinds, field widths) and the core itself; nothing else.
`timescale 1ns / 1ps

module tb_layer_zorder_stack_core;

   localparam int MAX_LAYERS = 256;
   localparam int LONG_HOLD  = 250;       // cycles the sink refuses results once
   localparam int SETTLE     = 16;        // cycles watched after the last result

   // one result transaction, field for field as it leaves the core
   typedef struct packed {
      logic                            status;
      logic [lzs_pkg::SLOT_W-1:0]      slot;
      logic signed [lzs_pkg::HT_W-1:0] layer;
      logic signed [lzs_pkg::HT_W-1:0] top;
      logic                            redraw;
   } result_type;

   // one row of the directed table; fixed is used only where typed is set
   typedef struct packed {
      lzs_pkg::req_kind_type           kind;
      logic [lzs_pkg::SLOT_W-1:0]      slot;
      logic signed [lzs_pkg::HT_W-1:0] height;
      logic                            typed;
      result_type                      fixed;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [1:0]                      req_type;
   logic [lzs_pkg::SLOT_W-1:0]      req_slot;
   logic signed [lzs_pkg::HT_W-1:0] req_new_height;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_status;
   logic [lzs_pkg::SLOT_W-1:0]      rsp_slot_out;
   logic signed [lzs_pkg::HT_W-1:0] rsp_layer_height;
   logic signed [lzs_pkg::HT_W-1:0] rsp_top_height;
   logic                            rsp_redraw;

   // shadow copy of the layer pool and its stacking order
   bit                         slot_busy [MAX_LAYERS];
   int                         slot_level [MAX_LAYERS];
   logic [lzs_pkg::SLOT_W-1:0] stack_at [MAX_LAYERS];
   int                         stack_top;

   result_type             due_results [$];   // predicted results, oldest first
   int                     fail_count   = 0;
   int                     results_seen = 0;
   bit                     quiet        = 1'b0; // set for the final stretch: no idling
   bit                     long_hold_done = 1'b0;

   always #10 clock = ~clock;

   layer_zorder_stack_core #(
      .MAX_LAYERS(MAX_LAYERS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_new_height  (req_new_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_layer_height(rsp_layer_height),
      .rsp_top_height  (rsp_top_height),
      .rsp_redraw      (rsp_redraw)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Map a stacking height onto an index of the order array.
   function automatic int lvl(int h);
      if (h < 0) return 0;
      if (h >= MAX_LAYERS) return MAX_LAYERS - 1;
      return h;
   endfunction

   // Move a used slot to a requested height, shifting and renumbering every
   // entry in between. Returns 1 when the stacking order changed.
   function automatic bit relocate(int s, int want);
      int prev;
      int lim;
      int nh;
      prev = slot_level[s];
      // a visible slot already owns a place, so it may go no higher than top
      lim  = (prev >= 0) ? stack_top : stack_top + 1;
      nh   = want;
      if (nh > lim) nh = lim;
      if (nh < -1) nh = -1;
      if (nh == prev) return 1'b0;
      slot_level[s] = nh;
      if (prev > nh) begin
         if (nh >= 0) begin
            // downward: entries from nh up to prev-1 climb by one
            for (int h = prev; h > nh; h--) begin
               stack_at[lvl(h)] = stack_at[lvl(h - 1)];
               slot_level[stack_at[lvl(h)]] = h;
            end
            stack_at[lvl(nh)] = lzs_pkg::SLOT_W'(s);
         end else begin
            // hide: close the gap and lower the top
            for (int h = prev; h < stack_top; h++) begin
               stack_at[lvl(h)] = stack_at[lvl(h + 1)];
               slot_level[stack_at[lvl(h)]] = h;
            end
            stack_top--;
         end
      end else begin
         if (prev >= 0) begin
            // upward: the shift starts at the old height
            for (int h = prev; h < nh; h++) begin
               stack_at[lvl(h)] = stack_at[lvl(h + 1)];
               slot_level[stack_at[lvl(h)]] = h;
            end
            stack_at[lvl(nh)] = lzs_pkg::SLOT_W'(s);
         end else begin
            // reveal: open a gap at nh and raise the top
            for (int h = stack_top; h >= nh; h--) begin
               stack_at[lvl(h + 1)] = stack_at[lvl(h)];
               slot_level[stack_at[lvl(h + 1)]] = h + 1;
            end
            stack_at[lvl(nh)] = lzs_pkg::SLOT_W'(s);
            stack_top++;
         end
      end
      return 1'b1;
   endfunction

   // Apply one request to the shadow pool and return the result it yields.
   function automatic result_type stack_update(lzs_pkg::req_kind_type kind,
                                               logic [lzs_pkg::SLOT_W-1:0] s,
                                               logic signed [lzs_pkg::HT_W-1:0] h);
      result_type r;
      int      idx;
      bit      hit;
      bit      moved;
      idx      = s;
      moved    = 1'b0;
      r.status = 1'b0;
      r.slot   = s;
      r.layer  = lzs_pkg::HT_W'(-1);
      case (kind)
         lzs_pkg::REQ_ALLOC: begin
            hit = 1'b0;
            for (int i = 0; i < MAX_LAYERS; i++) begin
               if (!hit && !slot_busy[i]) begin
                  hit           = 1'b1;
                  slot_busy[i]  = 1'b1;
                  slot_level[i] = -1;
                  idx           = i;
               end
            end
            if (hit) begin
               r.slot = lzs_pkg::SLOT_W'(idx);
            end else begin
               // pool exhausted: report it and leave everything untouched
               r.status = 1'b1;
               r.slot   = '0;
            end
         end
         lzs_pkg::REQ_SET: begin
            if (slot_busy[idx]) moved = relocate(idx, h);
            r.layer = lzs_pkg::HT_W'(slot_level[idx]);
         end
         lzs_pkg::REQ_FREE: begin
            if (slot_level[idx] >= 0) moved = relocate(idx, -1);
            slot_busy[idx] = 1'b0;
            r.layer = lzs_pkg::HT_W'(slot_level[idx]);
         end
         default: begin
            r.layer = lzs_pkg::HT_W'(slot_level[idx]);
         end
      endcase
      r.top    = lzs_pkg::HT_W'(stack_top);
      r.redraw = moved;
      return r;
   endfunction

   // Find a slot in use, scanning upward from a random start; fall back to
   // the start itself when the pool is empty.
   function automatic logic [lzs_pkg::SLOT_W-1:0] busy_slot(
         logic [lzs_pkg::SLOT_W-1:0] start);
      int probe;
      for (int k = 0; k < MAX_LAYERS; k++) begin
         probe = (start + k) % MAX_LAYERS;
         if (slot_busy[probe]) return lzs_pkg::SLOT_W'(probe);
      end
      return start;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic mismatch(string what);
      $display("[%0t] result %0d: %s", $realtime, results_seen, what);
      fail_count++;
   endtask

   // Sample at the rising edge; compare each accepted result with the oldest
   // prediction.
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_slot_out, rsp_layer_height, rsp_top_height, rsp_redraw};
         results_seen++;
         if (due_results.size() == 0) begin
            mismatch("result transaction with nothing outstanding");
         end else begin
            want = due_results.pop_front();
            if (got.status !== want.status)
               mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.slot !== want.slot)
               mismatch($sformatf("slot_out got %0d want %0d", got.slot, want.slot));
            if (got.layer !== want.layer)
               mismatch($sformatf("layer_height got %0d want %0d", got.layer, want.layer));
            if (got.top !== want.top)
               mismatch($sformatf("top_height got %0d want %0d", got.top, want.top));
            if (got.redraw !== want.redraw)
               mismatch($sformatf("redraw got %0d want %0d", got.redraw, want.redraw));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result sink: random back-pressure, one long hold-off, none at the end
   // ---------------------------------------------------------------------

   initial begin : result_sink
      int span;
      int tick;
      rsp_ready = 1'b0;
      tick      = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (!long_hold_done && results_seen >= 100) begin
            // refuse results long enough for the core to fill and stall its input
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (!quiet && (tick % 300) < 200 && $urandom_range(0, 4) == 0) begin
            span = $urandom_range(1, 14);
            rsp_ready <= 1'b0;
            repeat (span - 1) @(negedge clock);
            tick += span - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request source
   // ---------------------------------------------------------------------

   // Offer one request from the falling edge, hold it until accepted, then
   // record what should come back.
   task automatic offer(lzs_pkg::req_kind_type kind, logic [lzs_pkg::SLOT_W-1:0] s,
                        logic signed [lzs_pkg::HT_W-1:0] h, bit typed, result_type fixed);
      result_type model_out;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_slot       <= s;
      req_new_height <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_out = stack_update(kind, s, h);
      due_results.push_back(typed ? fixed : model_out);
   endtask

   // Drop valid for a burst of cycles, with junk on the payload.
   task automatic pause_sender(int span);
      @(negedge clock);
      req_valid      <= 1'b0;
      req_type       <= 2'($urandom);
      req_slot       <= lzs_pkg::SLOT_W'($urandom);
      req_new_height <= lzs_pkg::HT_W'($urandom);
      repeat (span - 1) @(negedge clock);
   endtask

   // Drop valid and wait until every predicted result has arrived.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Weighted random traffic. Most set and free requests address a slot in
   // use, and most heights fall within reach of the current top, so the
   // shifts go deep; the remainder is noise over the full field ranges.
   task automatic random_items(int count, int p_alloc, int p_set, int p_free, bit gaps);
      int                              roll;
      lzs_pkg::req_kind_type           kind;
      logic [lzs_pkg::SLOT_W-1:0]      s;
      logic signed [lzs_pkg::HT_W-1:0] h;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         s    = lzs_pkg::SLOT_W'($urandom);
         h    = lzs_pkg::HT_W'($urandom);
         if (roll < p_alloc) begin
            kind = lzs_pkg::REQ_ALLOC;
         end else if (roll < p_alloc + p_set) begin
            kind = lzs_pkg::REQ_SET;
            if ($urandom_range(0, 9) != 0) s = busy_slot(s);
            if ($urandom_range(0, 4) != 0)
               h = lzs_pkg::HT_W'($urandom_range(0, stack_top + 2) - 1);
         end else if (roll < p_alloc + p_set + p_free) begin
            kind = lzs_pkg::REQ_FREE;
            if ($urandom_range(0, 7) != 0) s = busy_slot(s);
         end else begin
            kind = lzs_pkg::REQ_NOP;
         end
         // idle in bursts, with stretches of back-to-back traffic between
         if (gaps && (k % 64) < 44 && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 14));
         offer(kind, s, h, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      stim_row_type dir_tab [$];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = lzs_pkg::REQ_NOP;
      req_slot       = '0;
      req_new_height = '0;
      for (int i = 0; i < MAX_LAYERS; i++) begin
         slot_busy[i]  = 1'b0;
         slot_level[i] = -1;
         stack_at[i]   = '0;
      end
      stack_top = -1;

      // Directed table: empty pool, first allocations, clamping at both ends,
      // upward and downward moves, same height, hide, free visible and hidden.
      dir_tab.push_back('{lzs_pkg::REQ_NOP,   8'd0,   9'sd0,    1'b1,
                          '{1'b0, 8'd0,   -9'sd1, -9'sd1, 1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd255, 9'sd255,  1'b1,
                          '{1'b0, 8'd255, -9'sd1, -9'sd1, 1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_FREE,  8'd128, -9'sd1,   1'b1,
                          '{1'b0, 8'd128, -9'sd1, -9'sd1, 1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_ALLOC, 8'd0,   9'sd0,    1'b1,
                          '{1'b0, 8'd0,   -9'sd1, -9'sd1, 1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_ALLOC, 8'd77,  9'sd3,    1'b1,
                          '{1'b0, 8'd1,   -9'sd1, -9'sd1, 1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd0,   9'sd255,  1'b1,
                          '{1'b0, 8'd0,   9'sd0,  9'sd0,  1'b1}});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd1,   -9'sd256, 1'b1,
                          '{1'b0, 8'd1,   -9'sd1, 9'sd0,  1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd1,   9'sd0,    1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_ALLOC, 8'd255, -9'sd1,   1'b1,
                          '{1'b0, 8'd2,   -9'sd1, 9'sd1,  1'b0}});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd2,   9'sd100,  1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd1,   9'sd2,    1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd2,   9'sd0,    1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd1,   9'sd255,  1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd0,   -9'sd1,   1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_FREE,  8'd1,   9'sd0,    1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_FREE,  8'd0,   9'sd0,    1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_NOP,   8'd255, -9'sd1,   1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_SET,   8'd2,   -9'sd2,   1'b0, '0});
      dir_tab.push_back('{lzs_pkg::REQ_ALLOC, 8'hAA,  9'h0AA,   1'b0, '0});

      // hold reset, then release it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         offer(dir_tab[i].kind, dir_tab[i].slot, dir_tab[i].height,
               dir_tab[i].typed, dir_tab[i].fixed);

      random_items(300, 30, 50, 10, 1'b1);   // grow a mixed stack
      drain();                               // sender waits for every result
      random_items(350, 70, 20, 5, 1'b1);    // run the pool dry
      drain();
      random_items(300, 10, 45, 40, 1'b1);   // shrink it again
      quiet = 1'b1;
      random_items(250, 25, 50, 15, 1'b0);   // final stretch, no idling

      drain();
      repeat (SETTLE) @(posedge clock);
      if (due_results.size() != 0)
         mismatch($sformatf("%0d results never arrived", due_results.size()));
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: many times the slowest legal run.
   initial begin : watchdog
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
